@@ sv/sat_pkg.sv @@
// ----------------------------------------------------------------------------
// sat_pkg: shared types and constants for the shifting array table
// Opcodes, command and result structs, fixed field widths.
// ----------------------------------------------------------------------------
package sat_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned POS_W  = 6;
	localparam int unsigned CNT_W  = 7;

	localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

	typedef enum logic [1:0] {
		OP_APPEND  = 2'd0,
		OP_INSERT  = 2'd1,
		OP_DELETE  = 2'd2,
		OP_REVERSE = 2'd3
	} op_t;

	typedef struct packed {
		op_t                       op;
		logic [POS_W-1:0]          pos;
		logic signed [WORD_W-1:0]  word;
	} cmd_t;

	typedef struct packed {
		logic signed [WORD_W-1:0]  removed;
		logic                      ok;
		logic [CNT_W-1:0]          fill;
	} res_t;

endpackage

@@ sv/sat_if.sv @@
// ----------------------------------------------------------------------------
// sat_cmd_if / sat_rsp_if: command and result channels
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface sat_cmd_if;
	logic                                 valid;
	logic                                 ready;
	logic [1:0]                           opcode;
	logic [sat_pkg::POS_W-1:0]            position;
	logic signed [sat_pkg::WORD_W-1:0]    word_in;

	modport source (output valid, output opcode, output position, output word_in,
		input ready);
	modport sink (input valid, input opcode, input position, input word_in,
		output ready);
endinterface

interface sat_rsp_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [sat_pkg::WORD_W-1:0]    removed_word;
	logic                                 accepted;
	logic [sat_pkg::CNT_W-1:0]            fill_count;

	modport source (output valid, output removed_word, output accepted,
		output fill_count, input ready);
	modport sink (input valid, input removed_word, input accepted,
		input fill_count, output ready);
endinterface

@@ sv/shifting_array_table.sv @@
// ----------------------------------------------------------------------------
// shifting_array_table: ordered list of signed words with insert and delete
// Entry RAM walked by a sequencer; capacity register; registered result.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                  | transfer
//  cmd      | in  | opcode, position, word_in                | valid & ready
//  rsp      | out | removed_word, accepted, fill_count       | valid & ready
//  cfg      | in  | cfg_wdata (capacity_limit)               | cfg_we
//
//  Append writes at the fill count. Insert shifts the tail up from the end,
//  then writes the word. Delete captures the word, then shifts the tail down.
//  Reverse swaps pairs from both ends. Moves use the single RAM port pair.
//  Reset clears the fill count and sets capacity to 64; no RAM clear.
//  cmd.ready is low from a transfer until its result has been taken.
// ----------------------------------------------------------------------------
module shifting_array_table #(
	parameter int unsigned DEPTH = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	sat_cmd_if.sink                      cmd,
	sat_rsp_if.source                    rsp,
	input  logic                         cfg_we,
	input  logic [sat_pkg::CNT_W-1:0]    cfg_wdata
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = sat_pkg::CNT_W;

	logic [CW-1:0]               cap_q;
	logic [CW-1:0]               cap_eff;
	logic                        start;
	logic                        busy;
	logic                        done;
	sat_pkg::cmd_t               cmd_s;
	sat_pkg::res_t               res;
	sat_pkg::res_t               res_q;
	logic                        rsp_valid_q;
	logic                        ram_we;
	logic [AW-1:0]               ram_waddr;
	logic [sat_pkg::WORD_W-1:0]  ram_wdata;
	logic                        ram_re;
	logic [AW-1:0]               ram_raddr;
	logic [sat_pkg::WORD_W-1:0]  ram_rdata;

	assign cap_eff   = (32'(cap_q) < DEPTH) ? cap_q : CW'(DEPTH);
	assign cmd.ready = !busy && !rsp_valid_q;
	assign start     = cmd.valid && cmd.ready;
	assign cmd_s.op   = sat_pkg::op_t'(cmd.opcode);
	assign cmd_s.pos  = cmd.position;
	assign cmd_s.word = cmd.word_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= sat_pkg::CAP_RESET;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (done) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			res_q <= res;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.removed_word = res_q.removed;
	assign rsp.accepted     = res_q.ok;
	assign rsp.fill_count   = res_q.fill;

	sat_seq #(
		.DEPTH (DEPTH)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cmd       (cmd_s),
		.cap_eff   (cap_eff),
		.busy      (busy),
		.done      (done),
		.res       (res),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	sat_ram #(
		.WIDTH (sat_pkg::WORD_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.re      (ram_re),
		.raddr   (ram_raddr),
		.rdata_q (ram_rdata)
	);

endmodule

@@ sv/sat_ram.sv @@
// ----------------------------------------------------------------------------
// sat_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sat_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata_q
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

endmodule

@@ sv/sat_seq.sv @@
// ----------------------------------------------------------------------------
// sat_seq: list sequencer
// Walks the entry RAM one word per step to append, insert, delete, reverse.
// ----------------------------------------------------------------------------
module sat_seq #(
	parameter int unsigned DEPTH = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  sat_pkg::cmd_t                      cmd,
	input  logic [sat_pkg::CNT_W-1:0]          cap_eff,
	output logic                               busy,
	output logic                               done,
	output sat_pkg::res_t                      res,
	output logic                               ram_we,
	output logic [$clog2(DEPTH)-1:0]           ram_waddr,
	output logic [sat_pkg::WORD_W-1:0]         ram_wdata,
	output logic                               ram_re,
	output logic [$clog2(DEPTH)-1:0]           ram_raddr,
	input  logic [sat_pkg::WORD_W-1:0]         ram_rdata
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = sat_pkg::CNT_W;

	typedef enum logic [8:0] {
		ST_IDLE   = 9'b000000001,
		ST_SH_WR  = 9'b000000010,
		ST_PUT    = 9'b000000100,
		ST_DL_CAP = 9'b000001000,
		ST_DL_WR  = 9'b000010000,
		ST_RV_HI  = 9'b000100000,
		ST_RV_WLO = 9'b001000000,
		ST_RV_WHI = 9'b010000000,
		ST_DONE   = 9'b100000000
	} state_t;

	state_t                        state_q, state_d;
	logic [CW-1:0]                 cnt_q, cnt_d;
	logic [CW-1:0]                 i_q, i_d;
	logic [CW-1:0]                 hi_q, hi_d;
	logic                          ok_q, ok_d;
	logic [sat_pkg::WORD_W-1:0]    removed_q, removed_d;
	logic [sat_pkg::WORD_W-1:0]    tmp_q, tmp_d;
	logic [sat_pkg::POS_W-1:0]     pos_q;
	logic [sat_pkg::WORD_W-1:0]    word_q;
	logic [CW-1:0]                 pos_ext;
	logic                          room;

	assign pos_ext = CW'(cmd.pos);
	assign room    = cnt_q < cap_eff;

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		i_d       = i_q;
		hi_d      = hi_q;
		ok_d      = ok_q;
		removed_d = removed_q;
		tmp_d     = tmp_q;
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					removed_d = '0;
					ok_d      = 1'b0;
					state_d   = ST_DONE;
					unique case (cmd.op)
						sat_pkg::OP_APPEND: begin
							if (room) begin
								ram_we    = 1'b1;
								ram_waddr = AW'(cnt_q);
								ram_wdata = cmd.word;
								cnt_d     = cnt_q + 1'b1;
								ok_d      = 1'b1;
							end
						end
						sat_pkg::OP_INSERT: begin
							if (room && pos_ext <= cnt_q) begin
								ok_d = 1'b1;
								if (cnt_q > pos_ext) begin
									ram_re    = 1'b1;
									ram_raddr = AW'(cnt_q - 1'b1);
									i_d       = cnt_q;
									state_d   = ST_SH_WR;
								end else begin
									state_d = ST_PUT;
								end
							end
						end
						sat_pkg::OP_DELETE: begin
							if (pos_ext < cnt_q) begin
								ok_d      = 1'b1;
								ram_re    = 1'b1;
								ram_raddr = AW'(pos_ext);
								i_d       = pos_ext;
								state_d   = ST_DL_CAP;
							end
						end
						sat_pkg::OP_REVERSE: begin
							ok_d = 1'b1;
							if (cnt_q > CW'(1)) begin
								ram_re    = 1'b1;
								ram_raddr = '0;
								i_d       = '0;
								hi_d      = cnt_q - 1'b1;
								state_d   = ST_RV_HI;
							end
						end
						default: state_d = ST_DONE;
					endcase
				end
			end
			ST_SH_WR: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(i_q);
				ram_wdata = ram_rdata;
				i_d       = i_q - 1'b1;
				if ((i_q - 1'b1) > CW'(pos_q)) begin
					ram_re    = 1'b1;
					ram_raddr = AW'(i_q - CW'(2));
				end else begin
					state_d = ST_PUT;
				end
			end
			ST_PUT: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(pos_q);
				ram_wdata = word_q;
				cnt_d     = cnt_q + 1'b1;
				state_d   = ST_DONE;
			end
			ST_DL_CAP: begin
				removed_d = ram_rdata;
				if ((i_q + 1'b1) < cnt_q) begin
					ram_re    = 1'b1;
					ram_raddr = AW'(i_q + 1'b1);
					state_d   = ST_DL_WR;
				end else begin
					cnt_d   = cnt_q - 1'b1;
					state_d = ST_DONE;
				end
			end
			ST_DL_WR: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(i_q);
				ram_wdata = ram_rdata;
				i_d       = i_q + 1'b1;
				if ((i_q + CW'(2)) < cnt_q) begin
					ram_re    = 1'b1;
					ram_raddr = AW'(i_q + CW'(2));
				end else begin
					cnt_d   = cnt_q - 1'b1;
					state_d = ST_DONE;
				end
			end
			ST_RV_HI: begin
				tmp_d     = ram_rdata;
				ram_re    = 1'b1;
				ram_raddr = AW'(hi_q);
				state_d   = ST_RV_WLO;
			end
			ST_RV_WLO: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(i_q);
				ram_wdata = ram_rdata;
				state_d   = ST_RV_WHI;
			end
			ST_RV_WHI: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(hi_q);
				ram_wdata = tmp_q;
				i_d       = i_q + 1'b1;
				hi_d      = hi_q - 1'b1;
				if ((i_q + 1'b1) < (hi_q - 1'b1)) begin
					ram_re    = 1'b1;
					ram_raddr = AW'(i_q + 1'b1);
					state_d   = ST_RV_HI;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		i_q       <= i_d;
		hi_q      <= hi_d;
		ok_q      <= ok_d;
		removed_q <= removed_d;
		tmp_q     <= tmp_d;
		if (start && state_q == ST_IDLE) begin
			pos_q  <= cmd.pos;
			word_q <= cmd.word;
		end
	end

	assign busy        = state_q != ST_IDLE;
	assign done        = state_q == ST_DONE;
	assign res.removed = removed_q;
	assign res.ok      = ok_q;
	assign res.fill    = cnt_q;

endmodule

@@ sv/sat_chk.sv @@
// ----------------------------------------------------------------------------
// sat_chk: port-level checks for the shifting array table
// Watches command and result channels; bound to the top level.
// ----------------------------------------------------------------------------
module sat_chk (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              cmd_valid,
	input logic                              cmd_ready,
	input logic                              rsp_valid,
	input logic                              rsp_ready,
	input logic signed [sat_pkg::WORD_W-1:0] rsp_removed_word,
	input logic                              rsp_accepted
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped before transfer");

	a_no_cmd_while_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !cmd_ready)
		else $error("command taken while result pending");

	a_busy_after_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("command taken while previous one in progress");

	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_accepted |-> rsp_removed_word == '0)
		else $error("refused operation returned a word");

endmodule

bind shifting_array_table sat_chk u_sat_chk (
	.clk              (clk),
	.arst_n           (arst_n),
	.cmd_valid        (cmd.valid),
	.cmd_ready        (cmd.ready),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_removed_word (rsp.removed_word),
	.rsp_accepted     (rsp.accepted)
);
